// ===== rtl/uart_rb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Shared types, codes and sizes for the 16550-style UART register block.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

  // Receive FIFO sizing.
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Decoupling queue between the decoder and the execute stage.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Transaction kinds on the input channel.
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RECV  = 2'd2;

  // Register offsets.
  localparam logic [2:0] REG_RBR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_IIR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  // Interrupt identification codes.
  localparam logic [7:0] IIR_NONE = 8'h01;
  localparam logic [7:0] IIR_THRE = 8'h02;
  localparam logic [7:0] IIR_RXDA = 8'h04;

  // Fixed line status bits: transmitter always empty.
  localparam logic [7:0] LSR_TX_EMPTY = 8'h60;

  // Decoded operations handed from the front end to the execute stage.
  typedef logic [3:0] op_t;

  localparam op_t OP_NOP    = 4'd0;
  localparam op_t OP_RD_RBR = 4'd1;
  localparam op_t OP_RD_IER = 4'd2;
  localparam op_t OP_RD_IIR = 4'd3;
  localparam op_t OP_RD_LCR = 4'd4;
  localparam op_t OP_RD_MCR = 4'd5;
  localparam op_t OP_RD_LSR = 4'd6;
  localparam op_t OP_RD_SCR = 4'd7;
  localparam op_t OP_WR_THR = 4'd8;
  localparam op_t OP_WR_IER = 4'd9;
  localparam op_t OP_WR_FCR = 4'd10;
  localparam op_t OP_WR_LCR = 4'd11;
  localparam op_t OP_WR_MCR = 4'd12;
  localparam op_t OP_WR_SCR = 4'd13;
  localparam op_t OP_RECV   = 4'd14;

  // One queued operation with its data byte.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/uart_rb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uart_rb_front
// Classifies an incoming transaction into a register operation and selects
// the data byte that goes with it.
// ----------------------------------------------------------------------------
module uart_rb_front
  import uart_rb_pkg::*;
(
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_reg_offset,
  input  wire logic [7:0] in_write_data,
  input  wire logic [7:0] in_rx_byte,
  output item_t           item
);

  logic       offset_ok;
  logic [2:0] reg_sel;

  assign offset_ok = (in_reg_offset[7:3] == 5'd0);
  assign reg_sel   = in_reg_offset[2:0];

  // Decode action and offset. DLAB is resolved later, at execution.
  always_comb begin
    item.op   = OP_NOP;
    item.data = in_write_data;
    case (in_action)
      ACT_READ: begin
        if (offset_ok) begin
          case (reg_sel)
            REG_RBR: item.op = OP_RD_RBR;
            REG_IER: item.op = OP_RD_IER;
            REG_IIR: item.op = OP_RD_IIR;
            REG_LCR: item.op = OP_RD_LCR;
            REG_MCR: item.op = OP_RD_MCR;
            REG_LSR: item.op = OP_RD_LSR;
            REG_SCR: item.op = OP_RD_SCR;
            default: item.op = OP_NOP;
          endcase
        end
      end
      ACT_WRITE: begin
        if (offset_ok) begin
          case (reg_sel)
            REG_RBR: item.op = OP_WR_THR;
            REG_IER: item.op = OP_WR_IER;
            REG_IIR: item.op = OP_WR_FCR;
            REG_LCR: item.op = OP_WR_LCR;
            REG_MCR: item.op = OP_WR_MCR;
            REG_SCR: item.op = OP_WR_SCR;
            default: item.op = OP_NOP;
          endcase
        end
      end
      ACT_RECV: begin
        item.op   = OP_RECV;
        item.data = in_rx_byte;
      end
      default: item.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/uart_rb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uart_rb_queue
// Short FIFO of decoded operations between the front end and the execute
// stage.
// ----------------------------------------------------------------------------
module uart_rb_queue
  import uart_rb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_en,
  input  wire item_t wr_item,
  output logic       full,
  input  wire logic  rd_en,
  output item_t      rd_item,
  output logic       empty
);

  item_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/uart_rb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uart_rb_back
// Execute stage: holds the UART registers and receive FIFO, carries out one
// operation per cycle unless the output is stalled, and registers the result.
// ----------------------------------------------------------------------------
module uart_rb_back
  import uart_rb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  wire item_t q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [7:0] out_read_data,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_irq_line
);

  // Register file state.
  logic [7:0]       dll_r, dll_nxt;
  logic [7:0]       dlm_r, dlm_nxt;
  logic [3:0]       ier_r, ier_nxt;
  logic [7:0]       lcr_r, lcr_nxt;
  logic [7:0]       mcr_r, mcr_nxt;
  logic [7:0]       scr_r, scr_nxt;
  logic [7:0]       fcr_r, fcr_nxt;
  logic             fifo_on_r, fifo_on_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic             dr_r, dr_nxt;
  logic             ovr_r, ovr_nxt;
  logic [7:0]       iid_r, iid_nxt;
  logic             rxp_r, rxp_nxt;
  logic             txp_r, txp_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;

  // Receive FIFO storage.
  logic [7:0]       rx_store_r [FIFO_DEPTH];

  // Output register.
  logic             out_valid_r;
  logic [7:0]       rd_data_r, rd_data_nxt;
  logic             tx_valid_r, tx_valid_nxt;
  logic [7:0]       tx_byte_r, tx_byte_nxt;
  logic             irq_r, irq_nxt;

  // Execution helpers.
  logic             dlab;
  logic [7:0]       d;
  logic [7:0]       store_rdata;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W:0]   slot_sum;
  logic [PTR_W-1:0] push_slot;
  logic             push_en;
  logic [7:0]       push_byte;
  logic             fifo_full;
  logic             do_refresh;

  // Identification that the current enables and data-ready state call for.
  function automatic logic [7:0] calc_ident(input logic [3:0] ier, input logic dr);
    logic [7:0] code;
    if (ier[0] && dr) begin
      code = IIR_RXDA;
    end else if (ier[1]) begin
      code = IIR_THRE;
    end else begin
      code = IIR_NONE;
    end
    return code;
  endfunction

  assign dlab        = lcr_r[7];
  assign d           = q_item.data;
  assign store_rdata = rx_store_r[head_r];
  assign fifo_full   = (count_r >= CNT_W'(FIFO_DEPTH));
  assign head_inc    = (head_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;

  // Tail slot: head plus fill count, wrapped once.
  assign slot_sum  = {1'b0, head_r} + (PTR_W + 1)'(count_r);
  assign push_slot = (slot_sum >= (PTR_W + 1)'(FIFO_DEPTH))
                   ? PTR_W'(slot_sum - (PTR_W + 1)'(FIFO_DEPTH))
                   : PTR_W'(slot_sum);

  // Take the next operation whenever the output register can be loaded.
  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  // Operation execution.
  always_comb begin
    dll_nxt      = dll_r;
    dlm_nxt      = dlm_r;
    ier_nxt      = ier_r;
    lcr_nxt      = lcr_r;
    mcr_nxt      = mcr_r;
    scr_nxt      = scr_r;
    fcr_nxt      = fcr_r;
    fifo_on_nxt  = fifo_on_r;
    hold_nxt     = hold_r;
    dr_nxt       = dr_r;
    ovr_nxt      = ovr_r;
    iid_nxt      = iid_r;
    rxp_nxt      = rxp_r;
    txp_nxt      = txp_r;
    count_nxt    = count_r;
    head_nxt     = head_r;
    rd_data_nxt  = 8'h00;
    tx_valid_nxt = 1'b0;
    tx_byte_nxt  = 8'h00;
    push_en      = 1'b0;
    push_byte    = d;
    do_refresh   = 1'b0;

    if (q_pop) begin
      case (q_item.op)
        OP_RD_RBR: begin
          if (dlab) begin
            rd_data_nxt = dll_r;
          end else begin
            if (fifo_on_r) begin
              if (count_r != '0) begin
                rd_data_nxt = store_rdata;
                head_nxt    = head_inc;
                count_nxt   = count_r - 1'b1;
                if (count_r == CNT_W'(1)) begin
                  dr_nxt = 1'b0;
                end
              end
            end else begin
              rd_data_nxt = hold_r;
              dr_nxt      = 1'b0;
            end
            ovr_nxt    = 1'b0;
            do_refresh = 1'b1;
          end
        end
        OP_RD_IER: rd_data_nxt = dlab ? dlm_r : {4'h0, ier_r};
        OP_RD_IIR: begin
          rd_data_nxt = iid_r;
          if (iid_r == IIR_RXDA && rxp_r) begin
            rxp_nxt    = 1'b0;
            do_refresh = (calc_ident(ier_r, dr_r) == IIR_NONE);
          end else if (iid_r == IIR_THRE && txp_r) begin
            txp_nxt    = 1'b0;
            do_refresh = (calc_ident(ier_r, dr_r) == IIR_NONE);
          end
        end
        OP_RD_LCR: rd_data_nxt = lcr_r;
        OP_RD_MCR: rd_data_nxt = mcr_r;
        OP_RD_LSR: rd_data_nxt = LSR_TX_EMPTY | {6'd0, ovr_r, dr_r};
        OP_RD_SCR: rd_data_nxt = scr_r;
        OP_WR_THR: begin
          if (dlab) begin
            dll_nxt = d;
          end else begin
            tx_valid_nxt = 1'b1;
            tx_byte_nxt  = d;
            do_refresh   = 1'b1;
          end
        end
        OP_WR_IER: begin
          if (dlab) begin
            dlm_nxt = d;
          end else begin
            ier_nxt    = d[3:0];
            do_refresh = 1'b1;
          end
        end
        OP_WR_FCR: begin
          fcr_nxt     = d;
          fifo_on_nxt = d[0];
          if (d[0] && !fifo_on_r && dr_r) begin
            // Turning the FIFO on moves a waiting holding byte into it.
            if (!fifo_full) begin
              push_en   = 1'b1;
              push_byte = hold_r;
              count_nxt = count_r + 1'b1;
            end
            dr_nxt = (count_nxt != '0);
          end else if (!d[0] && fifo_on_r && count_r != '0) begin
            // Turning it off keeps only the oldest byte.
            hold_nxt  = store_rdata;
            count_nxt = '0;
            head_nxt  = '0;
            dr_nxt    = 1'b1;
          end
          if (d[1]) begin
            count_nxt  = '0;
            head_nxt   = '0;
            dr_nxt     = 1'b0;
            rxp_nxt    = 1'b0;
            do_refresh = 1'b1;
          end
        end
        OP_WR_LCR: lcr_nxt = d;
        OP_WR_MCR: mcr_nxt = d;
        OP_WR_SCR: scr_nxt = d;
        OP_RECV: begin
          if (fifo_on_r && fifo_full) begin
            ovr_nxt = 1'b1;
          end else begin
            if (fifo_on_r) begin
              push_en   = 1'b1;
              count_nxt = count_r + 1'b1;
            end else if (dr_r) begin
              ovr_nxt = 1'b1;
            end else begin
              hold_nxt = d;
            end
            dr_nxt     = 1'b1;
            do_refresh = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Refresh the interrupt identification from the updated state.
      if (do_refresh) begin
        iid_nxt = calc_ident(ier_nxt, dr_nxt);
        if (iid_nxt == IIR_RXDA) begin
          rxp_nxt = 1'b1;
        end else if (iid_nxt == IIR_THRE) begin
          txp_nxt = 1'b1;
        end else begin
          rxp_nxt = 1'b0;
          txp_nxt = 1'b0;
        end
      end
    end

    irq_nxt = (iid_nxt != IIR_NONE);
  end

  // Control and register state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dll_r       <= '0;
      dlm_r       <= '0;
      ier_r       <= '0;
      lcr_r       <= '0;
      mcr_r       <= '0;
      scr_r       <= '0;
      fcr_r       <= '0;
      fifo_on_r   <= 1'b0;
      hold_r      <= '0;
      dr_r        <= 1'b0;
      ovr_r       <= 1'b0;
      iid_r       <= IIR_NONE;
      rxp_r       <= 1'b0;
      txp_r       <= 1'b0;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dll_r       <= dll_nxt;
      dlm_r       <= dlm_nxt;
      ier_r       <= ier_nxt;
      lcr_r       <= lcr_nxt;
      mcr_r       <= mcr_nxt;
      scr_r       <= scr_nxt;
      fcr_r       <= fcr_nxt;
      fifo_on_r   <= fifo_on_nxt;
      hold_r      <= hold_nxt;
      dr_r        <= dr_nxt;
      ovr_r       <= ovr_nxt;
      iid_r       <= iid_nxt;
      rxp_r       <= rxp_nxt;
      txp_r       <= txp_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= q_pop ? 1'b1 : (out_valid_r && out_stall);
    end
  end

  // Result payload, loaded with each executed operation.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data_r  <= rd_data_nxt;
      tx_valid_r <= tx_valid_nxt;
      tx_byte_r  <= tx_byte_nxt;
      irq_r      <= irq_nxt;
    end
  end

  // Receive FIFO write port.
  always_ff @(posedge clk) begin
    if (push_en) begin
      rx_store_r[push_slot] <= push_byte;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = rd_data_r;
  assign out_tx_valid  = tx_valid_r;
  assign out_tx_byte   = tx_byte_r;
  assign out_irq_line  = irq_r;

  // The FIFO control register is kept but no field of it is read back.
  logic unused_fcr;
  assign unused_fcr = ^fcr_r;

endmodule
`default_nettype wire

// ===== rtl/uart_16550_register_block.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uart_16550_register_block
// 16550-style UART register file with a receive FIFO and interrupt
// identification, driven by a stream of bus reads, bus writes and received
// bytes.
// ----------------------------------------------------------------------------
// Every accepted transaction (bus read, bus write or received byte) yields
// exactly one result transaction carrying read data, an optional transmit
// byte and the interrupt level after that transaction. The block sustains
// one transaction per clock while out_stall is low: the decoder feeds a
// two-entry queue and the execute stage, which owns all registers and the
// receive FIFO, completes one operation per cycle into an output register
// unless the result side stalls. Each transaction is held in a queue entry,
// then in the output register. in_stall rises only when the queue is full
// because the result side is stalled. No clearing pass is needed after reset.
module uart_16550_register_block
  import uart_rb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_reg_offset,
  input  wire logic [7:0] in_write_data,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data,
  output logic            out_tx_valid,
  output logic [7:0]      out_tx_byte,
  output logic            out_irq_line
);

  item_t dec_item;
  item_t q_item;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  logic  q_push;

  // Decode the incoming transaction.
  uart_rb_front u_front (
    .in_action     (in_action),
    .in_reg_offset (in_reg_offset),
    .in_write_data (in_write_data),
    .in_rx_byte    (in_rx_byte),
    .item          (dec_item)
  );

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Decouple decoding from execution.
  uart_rb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (dec_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  // Execute and register the result.
  uart_rb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_tx_valid  (out_tx_valid),
    .out_tx_byte   (out_tx_byte),
    .out_irq_line  (out_irq_line)
  );

endmodule
`default_nettype wire
